[rtl/core/i2cm_pkg.sv]
`default_nettype none

package i2cm_pkg;

    // register indexes on the config port
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_TICKS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACK_TIMEOUT = 2'd1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_STA_A    = 4'd1;
    localparam logic [3:0] ST_STA_B    = 4'd2;
    localparam logic [3:0] ST_RSTART   = 4'd3;
    localparam logic [3:0] ST_BIT_LO   = 4'd4;
    localparam logic [3:0] ST_BIT_HI   = 4'd5;
    localparam logic [3:0] ST_ACK_LO   = 4'd6;
    localparam logic [3:0] ST_ACK_HI   = 4'd7;
    localparam logic [3:0] ST_ACK_POLL = 4'd8;
    localparam logic [3:0] ST_RD_LO    = 4'd9;
    localparam logic [3:0] ST_RD_HI    = 4'd10;
    localparam logic [3:0] ST_MACK_LO  = 4'd11;
    localparam logic [3:0] ST_MACK_HI  = 4'd12;
    localparam logic [3:0] ST_STOP_A   = 4'd13;
    localparam logic [3:0] ST_STOP_B   = 4'd14;
    localparam logic [3:0] ST_STOP_C   = 4'd15;

    // byte stage
    localparam logic [1:0] STG_SLA_W = 2'd0;
    localparam logic [1:0] STG_SUB   = 2'd1;
    localparam logic [1:0] STG_TX    = 2'd2;
    localparam logic [1:0] STG_RX    = 2'd3;

    // modes
    localparam logic [1:0] MODE_RX = 2'd0;
    localparam logic [1:0] MODE_TX = 2'd1;

    localparam logic [7:0] RW_CLR_MASK = 8'hFE;
    localparam logic [7:0] RW_RD_BIT   = 8'h01;

    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [7:0]  ack_timeout;
    } i2cm_cfg_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] mode;
        logic [7:0] slave_addr;
        logic [7:0] sub_addr;
        logic [7:0] length;
        logic [7:0] tx_byte;
        logic       sda_in;
    } i2cm_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       tx_taken;
        logic       busy_res;
        logic       done_res;
        logic       error;
    } i2cm_result_t;

endpackage

`default_nettype wire

[rtl/core/i2cm_seq.sv]
`default_nettype none

module i2cm_seq
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire i2cm_pkg::i2cm_item_t   item,
    input  wire i2cm_pkg::i2cm_cfg_t    cfg,
    output i2cm_pkg::i2cm_result_t      res
);
    import i2cm_pkg::*;

    logic [3:0]  st_reg,        st_next;
    logic [15:0] phase_cnt_reg, phase_cnt_next;
    logic [3:0]  bit_cnt_reg,   bit_cnt_next;
    logic [7:0]  shift_reg,     shift_next;
    logic [8:0]  bytes_left_reg, bytes_left_next;
    logic [1:0]  mode_reg,      mode_next;
    logic [7:0]  slave_reg,     slave_next;
    logic [7:0]  sub_reg,       sub_next;
    logic [8:0]  poll_cnt_reg,  poll_cnt_next;
    logic        err_flag_reg,  err_flag_next;
    logic [1:0]  stage_reg,     stage_next;

    logic [15:0] phase_len;
    logic [16:0] phase_inc;
    logic        phase_end;
    logic [3:0]  bit_inc;
    logic [8:0]  bytes_dec;
    logic [8:0]  poll_inc;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        tx_taken;
    logic        done;
    logic        err;
    logic        scl;
    logic        sda;

    assign phase_len = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
    assign phase_inc = {1'b0, phase_cnt_reg} + 17'd1;
    assign phase_end = phase_inc >= {1'b0, phase_len};
    assign bit_inc   = bit_cnt_reg + 4'd1;
    assign bytes_dec = (bytes_left_reg != 9'd0) ? bytes_left_reg - 9'd1 : 9'd0;
    assign poll_inc  = poll_cnt_reg + 9'd1;

    always_comb
    begin
        st_next         = st_reg;
        phase_cnt_next  = phase_cnt_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        mode_next       = mode_reg;
        slave_next      = slave_reg;
        sub_next        = sub_reg;
        poll_cnt_next   = poll_cnt_reg;
        err_flag_next   = err_flag_reg;
        stage_next      = stage_reg;
        rx_valid        = 1'b0;
        rx_byte         = 8'd0;
        tx_taken        = 1'b0;
        done            = 1'b0;
        err             = 1'b0;

        // timed phases advance the counter every tick
        if (st_reg != ST_IDLE && st_reg != ST_ACK_POLL)
        begin
            phase_cnt_next = phase_end ? 16'd0 : phase_inc[15:0];
        end

        case (st_reg)
            ST_IDLE:
            begin
                if (item.kind)
                begin
                    mode_next       = item.mode;
                    slave_next      = item.slave_addr;
                    sub_next        = item.sub_addr;
                    bytes_left_next = (item.length == 8'd0) ? 9'd256 : {1'b0, item.length};
                    err_flag_next   = 1'b0;
                    poll_cnt_next   = 9'd0;
                    stage_next      = (item.mode == MODE_RX) ? STG_RX : STG_SLA_W;
                    st_next         = ST_STA_A;
                    phase_cnt_next  = 16'd0;
                end
            end
            ST_STA_A:
            begin
                if (phase_end)
                    st_next = ST_STA_B;
            end
            ST_STA_B:
            begin
                if (phase_end)
                begin
                    shift_next   = (stage_reg == STG_RX) ? (slave_reg | RW_RD_BIT)
                                                         : (slave_reg & RW_CLR_MASK);
                    bit_cnt_next = 4'd0;
                    st_next      = ST_BIT_LO;
                end
            end
            ST_RSTART:
            begin
                if (phase_end)
                    st_next = ST_STA_A;
            end
            ST_BIT_LO:
            begin
                if (phase_end)
                    st_next = ST_BIT_HI;
            end
            ST_BIT_HI:
            begin
                if (phase_end)
                begin
                    shift_next   = {shift_reg[6:0], 1'b0};
                    bit_cnt_next = bit_inc;
                    if (bit_inc[3])
                    begin
                        poll_cnt_next = 9'd0;
                        st_next       = ST_ACK_LO;
                    end
                    else
                    begin
                        st_next = ST_BIT_LO;
                    end
                end
            end
            ST_ACK_LO:
            begin
                if (phase_end)
                    st_next = ST_ACK_HI;
            end
            ST_ACK_HI:
            begin
                if (phase_end)
                    st_next = ST_ACK_POLL;
            end
            ST_ACK_POLL:
            begin
                phase_cnt_next = 16'd0;
                if (!item.sda_in)
                begin
                    case (stage_reg)
                        STG_SLA_W:
                        begin
                            stage_next   = STG_SUB;
                            shift_next   = sub_reg;
                            bit_cnt_next = 4'd0;
                            st_next      = ST_BIT_LO;
                        end
                        STG_SUB:
                        begin
                            if (mode_reg == MODE_TX)
                            begin
                                stage_next   = STG_TX;
                                shift_next   = item.tx_byte;
                                bit_cnt_next = 4'd0;
                                tx_taken     = 1'b1;
                                st_next      = ST_BIT_LO;
                            end
                            else
                            begin
                                stage_next = STG_RX;
                                st_next    = ST_RSTART;
                            end
                        end
                        STG_TX:
                        begin
                            bytes_left_next = bytes_dec;
                            if (bytes_dec == 9'd0)
                            begin
                                st_next = ST_STOP_A;
                            end
                            else
                            begin
                                shift_next   = item.tx_byte;
                                bit_cnt_next = 4'd0;
                                tx_taken     = 1'b1;
                                st_next      = ST_BIT_LO;
                            end
                        end
                        default:
                        begin
                            shift_next   = 8'd0;
                            bit_cnt_next = 4'd0;
                            st_next      = ST_RD_LO;
                        end
                    endcase
                end
                else
                begin
                    poll_cnt_next = poll_inc;
                    if (poll_inc > {1'b0, cfg.ack_timeout})
                    begin
                        err_flag_next = 1'b1;
                        st_next       = ST_STOP_A;
                    end
                end
            end
            ST_RD_LO:
            begin
                if (phase_end)
                    st_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                if (phase_end)
                begin
                    shift_next   = {shift_reg[6:0], item.sda_in};
                    bit_cnt_next = bit_inc;
                    if (bit_inc[3])
                    begin
                        rx_byte         = {shift_reg[6:0], item.sda_in};
                        rx_valid        = 1'b1;
                        bytes_left_next = bytes_dec;
                        st_next         = ST_MACK_LO;
                    end
                    else
                    begin
                        st_next = ST_RD_LO;
                    end
                end
            end
            ST_MACK_LO:
            begin
                if (phase_end)
                    st_next = ST_MACK_HI;
            end
            ST_MACK_HI:
            begin
                if (phase_end)
                begin
                    if (bytes_left_reg == 9'd0)
                    begin
                        st_next = ST_STOP_A;
                    end
                    else
                    begin
                        shift_next   = 8'd0;
                        bit_cnt_next = 4'd0;
                        st_next      = ST_RD_LO;
                    end
                end
            end
            ST_STOP_A:
            begin
                if (phase_end)
                    st_next = ST_STOP_B;
            end
            ST_STOP_B:
            begin
                if (phase_end)
                    st_next = ST_STOP_C;
            end
            ST_STOP_C:
            begin
                if (phase_end)
                begin
                    done    = 1'b1;
                    err     = err_flag_reg;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next        = ST_IDLE;
                phase_cnt_next = 16'd0;
            end
        endcase
    end

    // bus levels follow the updated state
    always_comb
    begin
        case (st_next)
            ST_STA_B:   begin scl = 1'b1; sda = 1'b0;           end
            ST_RSTART:  begin scl = 1'b0; sda = 1'b1;           end
            ST_BIT_LO:  begin scl = 1'b0; sda = shift_next[7];  end
            ST_BIT_HI:  begin scl = 1'b1; sda = shift_next[7];  end
            ST_ACK_LO:  begin scl = 1'b0; sda = 1'b1;           end
            ST_RD_LO:   begin scl = 1'b0; sda = 1'b1;           end
            ST_MACK_LO: begin scl = 1'b0; sda = (bytes_left_next == 9'd0); end
            ST_MACK_HI: begin scl = 1'b1; sda = (bytes_left_next == 9'd0); end
            ST_STOP_A:  begin scl = 1'b0; sda = 1'b0;           end
            ST_STOP_B:  begin scl = 1'b1; sda = 1'b0;           end
            default:    begin scl = 1'b1; sda = 1'b1;           end
        endcase
    end

    always_comb
    begin
        res.scl_out  = scl;
        res.sda_out  = sda;
        res.rx_byte  = rx_byte;
        res.rx_valid = rx_valid;
        res.tx_taken = tx_taken;
        res.busy_res = (st_next != ST_IDLE);
        res.done_res = done;
        res.error    = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            phase_cnt_reg  <= 16'd0;
            bit_cnt_reg    <= 4'd0;
            shift_reg      <= 8'd0;
            bytes_left_reg <= 9'd0;
            mode_reg       <= 2'd0;
            slave_reg      <= 8'd0;
            sub_reg        <= 8'd0;
            poll_cnt_reg   <= 9'd0;
            err_flag_reg   <= 1'b0;
            stage_reg      <= STG_SLA_W;
        end
        else if (step)
        begin
            st_reg         <= st_next;
            phase_cnt_reg  <= phase_cnt_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            bytes_left_reg <= bytes_left_next;
            mode_reg       <= mode_next;
            slave_reg      <= slave_next;
            sub_reg        <= sub_next;
            poll_cnt_reg   <= poll_cnt_next;
            err_flag_reg   <= err_flag_next;
            stage_reg      <= stage_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/i2c_master_transaction_engine.sv]
// channel    direction  payload
// s_axis     in         one bus tick request: start command fields, tx byte, sampled SDA
// m_axis     out        one result per request: SCL/SDA levels, rx byte, status
// cfg        in         register writes: phase_ticks (0), ack_timeout (1)
//
// One request is taken per cycle while s_axis_tready is high; its result is registered and shows in the next cycle.
// The sequencer state updates only on an accepted request.
// s_axis_tready is low only while a result sits in the output register and m_axis_tready is low.
// Reset clears the sequencer to idle and the registers to phase_ticks 100, ack_timeout 250.

`default_nettype none

module i2c_master_transaction_engine
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [39:0]                      s_axis_tdata,  // mode, slave_addr, sub_addr,
                                                                 // length, tx_byte, sda_in
    input  wire logic                             s_axis_tuser,  // kind

    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [15:0]                           m_axis_tdata,  // scl_out, sda_out, rx_byte,
                                                                 // rx_valid, tx_taken,
                                                                 // busy_res, done_res, error

    input  wire logic                             cfg_we,
    input  wire logic [i2cm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import i2cm_pkg::*;

    i2cm_cfg_t    cfg_reg;
    i2cm_item_t   item;
    i2cm_result_t res;
    logic         accept;
    logic         out_valid_reg;
    logic [15:0]  out_data_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        item.kind       = s_axis_tuser;
        item.mode       = s_axis_tdata[1:0];
        item.slave_addr = s_axis_tdata[9:2];
        item.sub_addr   = s_axis_tdata[17:10];
        item.length     = s_axis_tdata[25:18];
        item.tx_byte    = s_axis_tdata[33:26];
        item.sda_in     = s_axis_tdata[34];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_ticks <= PHASE_TICKS_RST;
            cfg_reg.ack_timeout <= ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_PHASE_TICKS)
                cfg_reg.phase_ticks <= cfg_data;
            else if (cfg_addr == REG_ACK_TIMEOUT)
                cfg_reg.ack_timeout <= cfg_data[7:0];
        end
    end

    i2cm_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .item  (item),
        .cfg   (cfg_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {1'b0, res.error, res.done_res, res.busy_res, res.tx_taken,
                             res.rx_valid, res.rx_byte, res.sda_out, res.scl_out};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

[rtl/core/i2cm_checker.sv]
`default_nettype none

module i2cm_checker
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tready,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [15:0]  m_axis_tdata
);

    // done ends the transaction: never busy in the same result
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> !m_axis_tdata[12])
        else $error("done with busy set");

    // error only comes with done
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tdata[13])
        else $error("error without done");

    // a byte is either received or loaded, and only inside a transaction
    a_rx_tx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[10] || m_axis_tdata[11])
        |-> m_axis_tdata[12] && !(m_axis_tdata[10] && m_axis_tdata[11]))
        else $error("bad rx/tx flags");

    // the input side is never stalled while the output register is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled without back-pressure");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind i2c_master_transaction_engine i2cm_checker u_chk (.*);

`default_nettype wire

[verif/i2cm_bus_checker.sv]
`timescale 1ns / 100ps

module i2cm_bus_checker
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             s_axis_tvalid,
    input  wire logic                             s_axis_tready,
    input  wire logic [39:0]                      s_axis_tdata,  // mode, slave_addr, sub_addr,
                                                                 // length, tx_byte, sda_in
    input  wire logic                             s_axis_tuser,  // kind

    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic [15:0]                      m_axis_tdata,  // scl_out, sda_out, rx_byte,
                                                                 // rx_valid, tx_taken,
                                                                 // busy_res, done_res, error

    input  wire logic                             cfg_we,
    input  wire logic [i2cm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data,

    output int                                    fail_count,
    output int                                    queued,
    output logic                                  seq_busy,
    output int                                    done_total
);
    import i2cm_pkg::*;

    logic [15:0]  phase_len;
    logic [7:0]   ack_limit;

    logic [3:0]   st;
    logic [15:0]  ph_cnt;
    logic [3:0]   bit_cnt;
    logic [7:0]   shreg;
    logic [8:0]   bytes_left;
    logic [1:0]   mode_q;
    logic [1:0]   stage;
    logic [7:0]   sla_q;
    logic [7:0]   sub_q;
    logic [8:0]   polls;
    logic         nack_q;

    int           fails;
    int           dones;

    i2cm_result_t expected_bus_q[$];

    function automatic logic phase_over();
        logic [16:0] nxt;
        logic [16:0] len;
        len = (phase_len == 16'd0) ? 17'd1 : {1'b0, phase_len};
        nxt = {1'b0, ph_cnt} + 17'd1;
        if (nxt >= len)
        begin
            ph_cnt = 16'd0;
            return 1'b1;
        end
        ph_cnt = nxt[15:0];
        return 1'b0;
    endfunction

    function automatic void enter(input logic [3:0] nxt_st);
        st = nxt_st;
        ph_cnt = 16'd0;
    endfunction

    function automatic void load_byte(input logic [7:0] b);
        shreg = b;
        bit_cnt = 4'd0;
        enter(ST_BIT_LO);
    endfunction

    // one bus tick: advance the sequencer, then derive the line levels
    function automatic i2cm_result_t step_sequencer(input logic kind, input logic [39:0] d);
        i2cm_result_t r;
        logic         sda_in;
        logic [7:0]   tx;
        r = '0;
        sda_in = d[34];
        tx = d[33:26];
        case (st)
            ST_IDLE:
                if (kind)
                begin
                    mode_q = d[1:0];
                    sla_q = d[9:2];
                    sub_q = d[17:10];
                    bytes_left = (d[25:18] == 8'd0) ? 9'd256 : {1'b0, d[25:18]};
                    nack_q = 1'b0;
                    polls = 9'd0;
                    stage = (mode_q == MODE_RX) ? STG_RX : STG_SLA_W;
                    enter(ST_STA_A);
                end
            ST_STA_A:
                if (phase_over())
                    enter(ST_STA_B);
            ST_STA_B:
                if (phase_over())
                begin
                    if (stage == STG_RX)
                        load_byte(sla_q | RW_RD_BIT);
                    else
                        load_byte(sla_q & RW_CLR_MASK);
                end
            ST_RSTART:
                if (phase_over())
                    enter(ST_STA_A);
            ST_BIT_LO:
                if (phase_over())
                    enter(ST_BIT_HI);
            ST_BIT_HI:
                if (phase_over())
                begin
                    shreg = shreg << 1;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8)
                    begin
                        polls = 9'd0;
                        enter(ST_ACK_LO);
                    end
                    else
                        enter(ST_BIT_LO);
                end
            ST_ACK_LO:
                if (phase_over())
                    enter(ST_ACK_HI);
            ST_ACK_HI:
                if (phase_over())
                    enter(ST_ACK_POLL);
            ST_ACK_POLL:
                if (!sda_in)
                begin
                    case (stage)
                        STG_SLA_W:
                        begin
                            stage = STG_SUB;
                            load_byte(sub_q);
                        end
                        STG_SUB:
                            if (mode_q == MODE_TX)
                            begin
                                stage = STG_TX;
                                load_byte(tx);
                                r.tx_taken = 1'b1;
                            end
                            else
                            begin
                                stage = STG_RX;
                                enter(ST_RSTART);
                            end
                        STG_TX:
                        begin
                            if (bytes_left != 9'd0)
                                bytes_left = bytes_left - 9'd1;
                            if (bytes_left == 9'd0)
                                enter(ST_STOP_A);
                            else
                            begin
                                load_byte(tx);
                                r.tx_taken = 1'b1;
                            end
                        end
                        default:
                        begin
                            shreg = 8'd0;
                            bit_cnt = 4'd0;
                            enter(ST_RD_LO);
                        end
                    endcase
                end
                else
                begin
                    polls = polls + 9'd1;
                    if (polls > {1'b0, ack_limit})
                    begin
                        nack_q = 1'b1;
                        enter(ST_STOP_A);
                    end
                end
            ST_RD_LO:
                if (phase_over())
                    enter(ST_RD_HI);
            ST_RD_HI:
                if (phase_over())
                begin
                    shreg = {shreg[6:0], sda_in};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8)
                    begin
                        r.rx_byte = shreg;
                        r.rx_valid = 1'b1;
                        if (bytes_left != 9'd0)
                            bytes_left = bytes_left - 9'd1;
                        enter(ST_MACK_LO);
                    end
                    else
                        enter(ST_RD_LO);
                end
            ST_MACK_LO:
                if (phase_over())
                    enter(ST_MACK_HI);
            ST_MACK_HI:
                if (phase_over())
                begin
                    if (bytes_left == 9'd0)
                        enter(ST_STOP_A);
                    else
                    begin
                        shreg = 8'd0;
                        bit_cnt = 4'd0;
                        enter(ST_RD_LO);
                    end
                end
            ST_STOP_A:
                if (phase_over())
                    enter(ST_STOP_B);
            ST_STOP_B:
                if (phase_over())
                    enter(ST_STOP_C);
            default:
                if (phase_over())
                begin
                    r.done_res = 1'b1;
                    r.error = nack_q;
                    enter(ST_IDLE);
                end
        endcase

        r.scl_out = 1'b1;
        r.sda_out = 1'b1;
        case (st)
            ST_STA_B:
                r.sda_out = 1'b0;
            ST_RSTART:
                r.scl_out = 1'b0;
            ST_BIT_LO:
            begin
                r.scl_out = 1'b0;
                r.sda_out = shreg[7];
            end
            ST_BIT_HI:
                r.sda_out = shreg[7];
            ST_ACK_LO, ST_RD_LO:
                r.scl_out = 1'b0;
            ST_MACK_LO:
            begin
                r.scl_out = 1'b0;
                r.sda_out = (bytes_left == 9'd0);
            end
            ST_MACK_HI:
                r.sda_out = (bytes_left == 9'd0);
            ST_STOP_A:
            begin
                r.scl_out = 1'b0;
                r.sda_out = 1'b0;
            end
            ST_STOP_B:
                r.sda_out = 1'b0;
            default:
                ;
        endcase
        r.busy_res = (st != ST_IDLE);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] expv, input logic [7:0] actv);
        if (actv !== expv)
        begin
            $error("%s: expected %0h, got %0h", name, expv, actv);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        i2cm_result_t want;
        if (!rst_n)
        begin
            phase_len = PHASE_TICKS_RST;
            ack_limit = ACK_TIMEOUT_RST;
            st = ST_IDLE;
            ph_cnt = 16'd0;
            bit_cnt = 4'd0;
            shreg = 8'd0;
            bytes_left = 9'd0;
            mode_q = MODE_RX;
            stage = STG_SLA_W;
            sla_q = 8'd0;
            sub_q = 8'd0;
            polls = 9'd0;
            nack_q = 1'b0;
            fails = 0;
            dones = 0;
            expected_bus_q.delete();
            fail_count <= 0;
            queued <= 0;
            seq_busy <= 1'b0;
            done_total <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bus_q.size() == 0)
                begin
                    $error("result with no request waiting: %h", m_axis_tdata);
                    fails++;
                end
                else
                begin
                    want = expected_bus_q.pop_front();
                    check_field("scl_out", 8'(want.scl_out), 8'(m_axis_tdata[0]));
                    check_field("sda_out", 8'(want.sda_out), 8'(m_axis_tdata[1]));
                    check_field("rx_byte", want.rx_byte, m_axis_tdata[9:2]);
                    check_field("rx_valid", 8'(want.rx_valid), 8'(m_axis_tdata[10]));
                    check_field("tx_taken", 8'(want.tx_taken), 8'(m_axis_tdata[11]));
                    check_field("busy_res", 8'(want.busy_res), 8'(m_axis_tdata[12]));
                    check_field("done_res", 8'(want.done_res), 8'(m_axis_tdata[13]));
                    check_field("error", 8'(want.error), 8'(m_axis_tdata[14]));
                end
            end

            if (cfg_we)
            begin
                if (cfg_addr == REG_PHASE_TICKS)
                    phase_len = cfg_data;
                else if (cfg_addr == REG_ACK_TIMEOUT)
                    ack_limit = cfg_data[7:0];
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                want = step_sequencer(s_axis_tuser, s_axis_tdata);
                expected_bus_q.push_back(want);
                if (want.done_res)
                    dones++;
            end

            fail_count <= fails;
            queued <= expected_bus_q.size();
            seq_busy <= (st != ST_IDLE);
            done_total <= dones;
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    localparam logic [1:0] MODE_SUB_RX = 2'd2;   // subaddress, repeated start, receive
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

    logic                  clk;
    logic                  rst_n;

    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;
    logic                  s_axis_tuser;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;

    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    fail_count;
    int                    queued;
    logic                  seq_busy;
    int                    done_total;

    logic                  stall_on;
    int                    sda_hi_pct;
    int                    cycles = 0;
    int                    sent = 0;

    i2c_master_transaction_engine uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    i2cm_bus_checker u_bus_chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .queued        (queued),
        .seq_busy      (seq_busy),
        .done_total    (done_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("i2c_master_transaction_engine test failed");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !stall_on || ($urandom_range(0, 99) >= 22);
    end

    // one bus tick request; SDA from the emulated slave, tx byte always random
    task automatic bus_tick(input logic kind, input logic [1:0] mode, input logic [7:0] sla,
                            input logic [7:0] sub, input logic [7:0] len);
        logic       sda;
        logic [7:0] tx;
        while (stall_on && $urandom_range(0, 99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        sda = ($urandom_range(0, 99) < sda_hi_pct);
        tx = 8'($urandom_range(0, 255));
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {5'd0, sda, tx, len, sub, sla, mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
    endtask

    // random fields, short transactions
    task automatic rand_tick(input logic kind);
        bus_tick(kind, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 9))
                                             : 8'($urandom_range(1, 3)));
    endtask

    task automatic run_to_idle();
        do
            bus_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        while (seq_busy);
    endtask

    task automatic start_txn(input logic [1:0] mode, input logic [7:0] sla,
                             input logic [7:0] sub, input logic [7:0] len);
        bus_tick(1'b1, mode, sla, sub, len);
        run_to_idle();
    endtask

    task automatic hold_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (queued != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // register writes once the pipeline is empty; the sequencer may be mid-transaction
    task automatic load_regs(input logic [15:0] phase, input logic [7:0] ack);
        hold_for_drain();
        repeat (2) @(posedge clk);
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                  16'($urandom_range(0, 65535)));
        write_reg(REG_PHASE_TICKS, phase);
        write_reg(REG_ACK_TIMEOUT, {8'($urandom_range(0, 255)), ack});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] phase, input logic [7:0] ack);
        run_to_idle();
        load_regs(phase, ack);
    endtask

    initial
    begin
        int base;
        int seen;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser <= 1'b0;
        s_axis_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_data <= '0;
        stall_on = 1'b1;
        sda_hi_pct = 50;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing, 100 ticks per phase; start requests while busy are dropped
        bus_tick(1'b1, MODE_RX, 8'hFF, 8'h00, 8'd1);
        repeat (105) rand_tick($urandom_range(0, 7) == 0);
        load_regs(16'd1, 8'd3);
        run_to_idle();

        sda_hi_pct = 100;  // slave never answers
        start_txn(MODE_TX, 8'h42, 8'h01, 8'd1);

        // zero phase length acts as one; zero ack budget aborts on first miss
        set_regs(16'd0, 8'd0);
        sda_hi_pct = 40;
        start_txn(MODE_SUB_RX, 8'h33, 8'h44, 8'd2);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: load_regs(16'd1, 8'($urandom_range(0, 3)));
                1: load_regs(16'd2, 8'($urandom_range(4, 20)));
                2: load_regs(16'($urandom_range(1, 3)), 8'd255);
                3: load_regs(16'd0, 8'($urandom_range(0, 255)));
                default: load_regs(16'd1, 8'd0);
            endcase
            stall_on = (ph != 0);
            base = sent;
            seen = -1;
            while (sent < base + ((ph == 0) ? 70 : 50))
            begin
                if (done_total != seen)
                begin
                    seen = done_total;
                    case ($urandom_range(0, 9))
                        0: sda_hi_pct = 0;
                        1: sda_hi_pct = 100;
                        2: sda_hi_pct = 85;
                        default: sda_hi_pct = 50;
                    endcase
                end
                rand_tick($urandom_range(0, 7) == 0);
            end
        end

        // zero length runs 256 bytes, so the first bytes get an ACK from the master
        set_regs(16'd1, 8'd255);
        sda_hi_pct = 30;
        bus_tick(1'b1, MODE_SPARE == 2'd3 ? MODE_RX : MODE_RX, 8'h11, 8'h00, 8'd0);
        repeat (45) rand_tick(1'b0);
        load_regs(16'hFFFF, 8'd255);
        repeat (15) rand_tick(1'b0);

        hold_for_drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("i2c_master_transaction_engine test passed");
        else
            $display("i2c_master_transaction_engine test failed");
        $finish;
    end

endmodule
